### rtl/assert_macros.svh
// Assertion macros shared by the find-and-replace RTL.
// Each file that asserts has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define SFR_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/sfr_pkg.sv
// Types and constants for the stream find-and-replace block.
// No dependencies.
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 64;
  localparam int LEN_W     = 4;
  localparam int MAX_REPL  = 8;
  localparam int CNT_W     = $clog2(MAX_REPL + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_LEN   = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] pat_bytes;
    logic [LEN_W-1:0]  pat_len;
    logic [WORD_W-1:0] repl_bytes;
    logic [LEN_W-1:0]  repl_len;
  } cfg_t;

  // One step's worth of output bytes, queued between front and back.
  typedef struct packed {
    logic [MAX_REPL-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                count;
    logic                            last;
  } job_t;

endpackage

`default_nettype wire

### rtl/sfr_front.sv
// Front end: holds the match window, compares it against the pattern and
// turns each input beat into a job of up to eight output bytes. Uses sfr_pkg.
`default_nettype none
`include "assert_macros.svh"

module sfr_front #(
  parameter int MAX_PATTERN = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_fire,
  input  wire logic [sfr_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       in_last,
  input  wire sfr_pkg::cfg_t              cfg,
  output sfr_pkg::job_t                   job,
  output logic                            push
);

  localparam int FW = $clog2(MAX_PATTERN + 1);
  localparam int BW = sfr_pkg::BYTE_W;

  logic [BW-1:0] win_r   [MAX_PATTERN];
  logic [BW-1:0] win_nxt [MAX_PATTERN];
  logic [FW-1:0] fill_r, fill_nxt;

  logic [BW-1:0] comb     [MAX_PATTERN];
  logic [BW-1:0] comb_ext [2*MAX_PATTERN];
  logic [BW-1:0] slot_win [sfr_pkg::MAX_REPL];
  logic [MAX_PATTERN-1:0] lane_eq;

  logic [FW-1:0]               p_eff, t, drop;
  logic [sfr_pkg::CNT_W-1:0]   r_eff;
  logic                        match;

  // Clamp lengths to their legal ranges.
  always_comb begin
    if (cfg.pat_len == '0) begin
      p_eff = FW'(1);
    end else if ({1'b0, cfg.pat_len} > (sfr_pkg::LEN_W + 1)'(MAX_PATTERN)) begin
      p_eff = FW'(MAX_PATTERN);
    end else begin
      p_eff = FW'(cfg.pat_len);
    end
    if (cfg.repl_len == '0) begin
      r_eff = sfr_pkg::CNT_W'(1);
    end else if ({1'b0, cfg.repl_len} > (sfr_pkg::LEN_W + 1)'(sfr_pkg::MAX_REPL)) begin
      r_eff = sfr_pkg::CNT_W'(sfr_pkg::MAX_REPL);
    end else begin
      r_eff = sfr_pkg::CNT_W'(cfg.repl_len);
    end
  end

  // Window with the new byte appended at the fill position.
  genvar g;
  for (g = 0; g < MAX_PATTERN; g++) begin : g_lane
    assign comb[g]    = (FW'(g) < fill_r) ? win_r[g] : in_byte;
    assign lane_eq[g] = (FW'(g) >= p_eff) || (comb[g] == cfg.pat_bytes[g*BW +: BW]);
    assign comb_ext[g]               = comb[g];
    assign comb_ext[g + MAX_PATTERN] = '0;
  end

  for (g = 0; g < sfr_pkg::MAX_REPL; g++) begin : g_slot
    if (g < MAX_PATTERN) begin : g_win
      assign slot_win[g] = comb[g];
    end else begin : g_pad
      assign slot_win[g] = '0;
    end
  end

  assign t     = fill_r + FW'(1);
  assign match = (t == p_eff) && (&lane_eq);

  // Number of oldest window bytes passed through this beat.
  always_comb begin
    if (match) begin
      drop = '0;
    end else if (in_last) begin
      drop = t;
    end else if (t > p_eff) begin
      drop = t - p_eff;
    end else if (t == p_eff) begin
      drop = FW'(1);
    end else begin
      drop = '0;
    end
  end

  always_comb begin
    fill_nxt = (match || in_last) ? '0 : t - drop;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k];
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (drop == FW'(j)) begin
          win_nxt[k] = comb_ext[k + j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < sfr_pkg::MAX_REPL; i++) begin
      job.bytes[i] = match ? cfg.repl_bytes[i*BW +: BW] : slot_win[i];
    end
    job.count = match ? r_eff : sfr_pkg::CNT_W'(drop);
    job.last  = in_last;
  end

  assign push = in_fire && (job.count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_fire) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r <= win_nxt;
    end
  end

  `SFR_ASSERT(a_fill_bound, fill_r <= FW'(MAX_PATTERN - 1), "window fill out of range")
  `SFR_ASSERT_NXT(a_last_flush, in_fire && in_last, fill_r == '0, "window not flushed")

endmodule

`default_nettype wire

### rtl/sfr_queue.sv
// Short job queue between the front and back ends, held in flip-flops.
// Uses sfr_pkg for the job type.
`default_nettype none
`include "assert_macros.svh"

module sfr_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sfr_pkg::job_t push_job,
  input  wire logic          pop,
  output sfr_pkg::job_t      head,
  output logic               full,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfr_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wrap_inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= wrap_inc(rptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  `SFR_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `SFR_ASSERT(a_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

`default_nettype wire

### rtl/sfr_back.sv
// Back end: takes jobs from the queue and sends their bytes one beat at a
// time on the output channel. Uses sfr_pkg for the job type.
`default_nettype none
`include "assert_macros.svh"

module sfr_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sfr_pkg::job_t               head,
  input  wire logic                        q_empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_last
);

  localparam int IW = $clog2(sfr_pkg::MAX_REPL);
  localparam int CW = sfr_pkg::CNT_W;

  sfr_pkg::job_t cur_r;
  logic          vld_r;
  logic [IW-1:0] idx_r;
  logic          final_beat, take;

  assign final_beat = (CW'(idx_r) + CW'(1)) == cur_r.count;
  assign take       = !vld_r || (out_ready && final_beat);
  assign pop        = take && !q_empty;

  assign out_valid = vld_r;
  assign out_byte  = cur_r.bytes[idx_r];
  assign out_last  = cur_r.last && final_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (pop) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (vld_r && out_ready) begin
      // advance within the job, or go idle after its final beat
      if (final_beat) begin
        vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  `SFR_ASSERT(a_idx_in_job, !vld_r || (CW'(idx_r) < cur_r.count), "byte index past job end")

endmodule

`default_nettype wire

### rtl/stream_find_replace.sv
// Stream find-and-replace top level: config registers, front end, job queue
// and back end. Uses sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   input   | in_valid/in_ready, in_byte/last| in
//   output  | out_valid/out_ready, out_byte/l| out
//   config  | cfg_we, cfg_index, cfg_wdata   | in
//
// An input beat is taken every cycle while the job queue has room; each beat
// becomes one job of 0 to 8 output bytes. The back end sends one byte per
// cycle while out_ready is high; a byte is registered in the job queue and
// then in the back end's job register before it appears on the output.
// Reset clears the window fill, the queue and the output; config returns to
// a single zero-byte pattern and replacement, each of length one. The user
// must write config only while the block is idle; the block does not enforce it.
`default_nettype none

module stream_find_replace #(
  parameter int MAX_PATTERN = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    in_byte,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::WORD_W-1:0]    cfg_wdata
);

  sfr_pkg::cfg_t cfg_r;
  sfr_pkg::job_t new_job, head_job;
  logic          in_fire, push, pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_bytes  <= '0;
      cfg_r.pat_len    <= sfr_pkg::LEN_W'(1);
      cfg_r.repl_bytes <= '0;
      cfg_r.repl_len   <= sfr_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::CFG_PAT_BYTES:  cfg_r.pat_bytes  <= cfg_wdata;
        sfr_pkg::CFG_PAT_LEN:    cfg_r.pat_len    <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::CFG_REPL_BYTES: cfg_r.repl_bytes <= cfg_wdata;
        sfr_pkg::CFG_REPL_LEN:   cfg_r.repl_len   <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  sfr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .cfg     (cfg_r),
    .job     (new_job),
    .push    (push)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (new_job),
    .pop      (pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

### bench/tb_stream_find_replace.sv
`timescale 1ns / 1ps
// Testbench for stream_find_replace: directed and random texts checked beat by beat
// against an in-bench predictor of the find-and-replace window. Depends on sfr_pkg.

module tb_stream_find_replace;

  localparam int MAX_PAT        = 8;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_BEATS    = 26;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic [sfr_pkg::BYTE_W-1:0] data;
    logic                       last;
  } text_beat_t;

  typedef enum int {RX_FREE, RX_COIN, RX_CADENCE, RX_SLOW} rx_mode_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [sfr_pkg::BYTE_W-1:0]    in_byte;
  logic                          in_last;
  logic                          out_valid;
  logic                          out_ready;
  logic [sfr_pkg::BYTE_W-1:0]    out_byte;
  logic                          out_last;
  logic                          cfg_we;
  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sfr_pkg::WORD_W-1:0]    cfg_wdata;

  // predictor state and its copy of the registers
  logic [sfr_pkg::BYTE_W-1:0] hist [MAX_PAT];
  int unsigned                hist_fill;
  logic [sfr_pkg::WORD_W-1:0] find_word;
  logic [sfr_pkg::LEN_W-1:0]  find_len;
  logic [sfr_pkg::WORD_W-1:0] subst_word;
  logic [sfr_pkg::LEN_W-1:0]  subst_len;

  text_beat_t rewritten_q[$];

  int err_count;
  int beats_in;
  int beats_out;
  int cfg_writes;
  int replacements;
  int burst_left;
  int rx_hold_cycles;
  int stall_cycles;

  stream_find_replace #(.MAX_PATTERN(MAX_PAT)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_len(input logic [sfr_pkg::LEN_W-1:0] v,
                                          input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("MISMATCH %s: got %0h, want %0h at output beat %0d", what, got, want, beats_out);
    err_count++;
  endtask

  task automatic shift_out(inout int unsigned n);
    int k;
    if (hist_fill == 0) return;
    rewritten_q.push_back('{data: hist[0], last: 1'b0});
    for (k = 0; k < MAX_PAT - 1; k++) hist[k] = hist[k + 1];
    hist_fill--;
    n++;
  endtask

  task automatic predict_rewrite(input logic [sfr_pkg::BYTE_W-1:0] b, input logic last);
    int unsigned p, r, k, n;
    bit          hit;
    text_beat_t  tail;
    p   = eff_len(find_len, MAX_PAT);
    r   = eff_len(subst_len, sfr_pkg::MAX_REPL);
    n   = 0;
    hit = 1'b1;
    if (hist_fill >= MAX_PAT) shift_out(n);
    hist[hist_fill] = b;
    hist_fill++;
    if (hist_fill > p) begin
      // pattern got shorter: pass the excess through, no compare this beat
      while (hist_fill > p) shift_out(n);
    end else if (hist_fill == p) begin
      for (k = 0; k < p; k++)
        if (hist[k] != find_word[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        for (k = 0; k < r; k++) begin
          rewritten_q.push_back('{data: subst_word[8*k +: 8], last: 1'b0});
          n++;
        end
        hist_fill = 0;
        replacements++;
      end else begin
        shift_out(n);
      end
    end
    if (last) begin
      while (hist_fill > 0) shift_out(n);
      if (n > 0) begin
        tail = rewritten_q.pop_back();
        tail.last = 1'b1;
        rewritten_q.push_back(tail);
      end
    end
  endtask

  // Hold valid until the beat is taken; bursts and gaps come from burst_left.
  task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    predict_rewrite(b, last);
    beats_in++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected beat, then let the pipe go quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (rewritten_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfr_pkg::WORD_W-1:0]    data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      sfr_pkg::CFG_PAT_BYTES:  find_word  = data;
      sfr_pkg::CFG_PAT_LEN:    find_len   = data[sfr_pkg::LEN_W-1:0];
      sfr_pkg::CFG_REPL_BYTES: subst_word = data;
      sfr_pkg::CFG_REPL_LEN:   subst_len  = data[sfr_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  task automatic set_config(input logic [sfr_pkg::WORD_W-1:0] pw,
                            input logic [sfr_pkg::WORD_W-1:0] pl,
                            input logic [sfr_pkg::WORD_W-1:0] rw,
                            input logic [sfr_pkg::WORD_W-1:0] rl);
    cfg_write(sfr_pkg::CFG_PAT_BYTES, pw);
    cfg_write(sfr_pkg::CFG_PAT_LEN, pl);
    cfg_write(sfr_pkg::CFG_REPL_BYTES, rw);
    cfg_write(sfr_pkg::CFG_REPL_LEN, rl);
  endtask

  // Text built mostly from whole and partial copies of the pattern, plus noise.
  task automatic send_text(input int unsigned len, input bit close);
    logic [sfr_pkg::BYTE_W-1:0] txt[$];
    int unsigned                p, k, cut, kind, pos;
    p = eff_len(find_len, MAX_PAT);
    while (txt.size() < len) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        for (k = 0; k < p; k++) txt.push_back(find_word[8*k +: 8]);
      end else if (kind < 6) begin
        cut = $urandom_range(1, p);
        for (k = 0; k < cut; k++) txt.push_back(find_word[8*k +: 8]);
      end else if (kind < 8) begin
        pos = $urandom_range(0, p - 1);
        txt.push_back(find_word[8*pos +: 8]);
      end else begin
        txt.push_back(sfr_pkg::BYTE_W'($urandom));
      end
    end
    for (k = 0; k < txt.size(); k++)
      send_byte(txt[k], close && (k == txt.size() - 1));
  endtask

  function automatic logic [sfr_pkg::WORD_W-1:0] rand_len_word();
    int unsigned pick;
    logic [sfr_pkg::WORD_W-1:0] w;
    pick = $urandom_range(0, 9);
    w = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) w = '0;
    if (pick == 0) w[sfr_pkg::LEN_W-1:0] = '0;
    else if (pick == 1) w[sfr_pkg::LEN_W-1:0] = sfr_pkg::LEN_W'($urandom_range(9, 15));
    else w[sfr_pkg::LEN_W-1:0] = sfr_pkg::LEN_W'($urandom_range(1, 8));
    return w;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_config();
    wait_idle();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_length_zero();
    wait_idle();
    set_config(64'hFF, 64'd0, 64'h5A, 64'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_length_over_max();
    int k;
    wait_idle();
    set_config(64'h4847_4645_4443_4241, 64'hF, 64'hFEDC_BA98_7654_3210, 64'd9);
    // full-length match on the final beat: eight replacement bytes at once
    for (k = 0; k < MAX_PAT; k++)
      send_byte(sfr_pkg::BYTE_W'(8'h41 + k), k == MAX_PAT - 1);
  endtask

  task automatic test_partial_flush();
    wait_idle();
    set_config(64'h63_6261, 64'd3, 64'h7A79, 64'd2);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
  endtask

  task automatic test_overlap_leftmost();
    wait_idle();
    set_config(64'h6161, 64'd2, 64'h62, 64'd1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b1);
  endtask

  task automatic test_pattern_shrink_midtext();
    wait_idle();
    set_config(64'h7A79_7877, 64'd4, 64'h21, 64'd1);
    send_byte(8'h77, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h79, 1'b0);
    wait_idle();
    // window still holds three bytes; shorten the pattern under it
    cfg_write(sfr_pkg::CFG_PAT_BYTES, 64'h71);
    cfg_write(sfr_pkg::CFG_PAT_LEN, 64'd1);
    send_byte(8'h71, 1'b0);
    send_byte(8'h71, 1'b1);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    set_config({$urandom, $urandom}, 64'd2, {$urandom, $urandom}, 64'd8);
    rx_hold_cycles = HOLD_CYCLES;
    send_text(48, 1'b1);
  endtask

  task automatic test_random_texts();
    int          ph, start, tlen;
    bit          close;
    logic [sfr_pkg::WORD_W-1:0] pw;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: set_config('1, 64'd8, '0, 64'd8);
        1: set_config('0, 64'd1, '1, 64'd8);
        2: set_config({$urandom, $urandom}, 64'd8, {$urandom, $urandom}, 64'd1);
        default: begin
          pw = {$urandom, $urandom};
          // few distinct bytes give more partial matches
          if ($urandom_range(0, 1) == 0) pw = pw & 64'h0303_0303_0303_0303;
          set_config(pw, rand_len_word(), {$urandom, $urandom}, rand_len_word());
        end
      endcase
      start = beats_in;
      while (beats_in - start < PHASE_BEATS) begin
        tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        // the final text of a phase may stay open across the next config change
        close = (beats_in - start + tlen < PHASE_BEATS) || ($urandom_range(0, 2) != 0);
        send_text(tlen, close);
      end
    end
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    text_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rewritten_q.size() == 0) begin
        report_mismatch("unexpected beat", int'(out_byte), 0);
      end else begin
        want = rewritten_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", int'(out_byte), int'(want.data));
        if (out_last !== want.last)
          report_mismatch("out_last", int'(out_last), int'(want.last));
      end
      beats_out++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles, %0d beats still due",
                 stall_cycles, rewritten_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver: switch between stall patterns, plus one long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int left, tick, period, duty;
    out_ready = 1'b0;
    mode = RX_FREE;
    left = 0;
    tick = 0;
    period = 4;
    duty = 2;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode   = rx_mode_t'($urandom_range(0, 3));
        left   = $urandom_range(20, 200);
        period = $urandom_range(2, 9);
        duty   = $urandom_range(1, period - 1);
      end
      left--;
      tick++;
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:    out_ready <= 1'b1;
          RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
          RX_CADENCE: out_ready <= (tick % period) < duty;
          RX_SLOW:    out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = '0;
    in_last    = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = sfr_pkg::CFG_PAT_BYTES;
    cfg_wdata  = '0;
    hist_fill  = 0;
    find_word  = '0;
    find_len   = sfr_pkg::LEN_W'(1);
    subst_word = '0;
    subst_len  = sfr_pkg::LEN_W'(1);
    err_count  = 0;
    beats_in   = 0;
    beats_out  = 0;
    cfg_writes = 0;
    replacements   = 0;
    burst_left     = 0;
    rx_hold_cycles = 0;
    stall_cycles   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_config();
    test_length_zero();
    test_length_over_max();
    test_partial_flush();
    test_overlap_leftmost();
    test_pattern_shrink_midtext();
    test_output_backpressure();
    test_random_texts();

    wait_idle();
    if (rewritten_q.size() != 0) report_mismatch("beats never sent", 0, rewritten_q.size());
    $display("Run covered %0d input beats, %0d register writes, %0d output beats, %0d replacements.",
             beats_in, cfg_writes, beats_out, replacements);
    $display("Lengths 0 to 15, pattern shrink mid-text and a %0d-cycle output hold-off included.",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
